FILE: hw/rtl/mrtu_pkg.sv
`timescale 1ns / 1ps

package mrtu_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
    logic       button_pressed;
  } rx_word_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       led_on;
  } tx_word_t;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [7:0]  FC_WRITE_COIL = 8'h05;
  localparam logic [7:0]  FC_READ_INPUT = 8'h02;
  localparam logic [7:0]  COIL_ON       = 8'hFF;
  localparam logic [7:0]  COIL_OFF      = 8'h00;
  localparam logic [7:0]  READ_BYTE_CNT = 8'h01;
  localparam int          MIN_FRAME     = 8;
  localparam int          HDR_BYTES     = 8;

  // positions within the frame and the reply
  localparam logic [2:0] POS_ADDR       = 3'd0;
  localparam logic [2:0] POS_FUNC       = 3'd1;
  localparam logic [2:0] POS_BYTE_CNT   = 3'd2;
  localparam logic [2:0] POS_COIL       = 3'd4;
  localparam logic [2:0] POS_BUTTON     = 3'd3;
  localparam logic [2:0] POS_CRC_LO     = 3'd4;
  localparam logic [2:0] POS_CRC_HI     = 3'd5;
  localparam logic [2:0] ECHO_LAST      = 3'd7;
  localparam logic [2:0] REPLY_LAST     = 3'd5;
  localparam logic [2:0] REPLY_CRC_LAST = 3'd3;

  typedef struct packed {
    logic accept;    // take the input word
    logic shift;     // one crc bit step
    logic check;     // evaluate frame and rearm receiver
    logic rxor;      // fold reply byte into crc
    logic idx_inc;
    logic idx_clr;
    logic out_load;  // put one reply word in the output register
    logic crc_init;
  } mrtu_cmd_t;

  typedef struct packed {
    logic room;       // buffer not yet full
    logic end_held;   // latched frame end mark
    logic bit_last;
    logic frame_ok;
    logic is_coil;
    logic is_read;
    logic crc_last;   // last reply byte before the crc
    logic emit_last;
    logic out_free;
  } mrtu_sts_t;

endpackage

FILE: hw/rtl/modbus_rtu_slave_responder.sv
`timescale 1ns / 1ps

// Modbus RTU slave responder. Frame bytes come in one word at a time, the last one flagged
// by frame_end. Each byte that fits the buffer is accepted and then run through 8 steps of
// the bit-serial CRC-16 unit; a byte past a full buffer is only accepted. At frame end the
// check state tests length, address and CRC. A write-coil frame then echoes its first 8 bytes, one word per
// cycle while the output is not stalled; a read-input frame first runs the 4 reply bytes
// through the same CRC unit and then sends 6 words. Frames that fail a check
// or carry another function code give no words. The next input word is taken once the
// last reply word sits in the output register. slave_address resets to 1.
module modbus_rtu_slave_responder
  import mrtu_pkg::*;
#(
  parameter int FRAME_BUFFER_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  rx_word_t   in_word,
  output logic       out_valid,
  input  logic       out_stall,
  output tx_word_t   out_word
);

  mrtu_cmd_t cmd;
  mrtu_sts_t sts;
  logic      idle;

  assign in_stall = !idle;

  mrtu_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_take (in_valid && !in_stall),
    .in_end  (in_word.frame_end),
    .sts     (sts),
    .idle    (idle),
    .cmd     (cmd)
  );

  mrtu_datapath #(
    .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_word     (in_word),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_word    (out_word)
  );

endmodule

FILE: hw/rtl/mrtu_ctrl.sv
`timescale 1ns / 1ps

module mrtu_ctrl
  import mrtu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_take,
  input  logic       in_end,
  input  mrtu_sts_t  sts,
  output logic       idle,
  output mrtu_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FOLD  = 6'b000010,
    S_CHECK = 6'b000100,
    S_RXOR  = 6'b001000,
    S_RFOLD = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign idle = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          cmd.accept = 1'b1;
          if (sts.room) begin
            state_next = S_FOLD;
          end else if (in_end) begin
            state_next = S_CHECK;
          end
        end
      end
      S_FOLD: begin
        cmd.shift = 1'b1;
        if (sts.bit_last) begin
          state_next = sts.end_held ? S_CHECK : S_IDLE;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.frame_ok && sts.is_coil) begin
          state_next = S_EMIT;
        end else if (sts.frame_ok && sts.is_read) begin
          state_next = S_RXOR;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_RXOR: begin
        cmd.rxor = 1'b1;
        state_next = S_RFOLD;
      end
      S_RFOLD: begin
        cmd.shift = 1'b1;
        if (sts.bit_last) begin
          if (sts.crc_last) begin
            cmd.idx_clr = 1'b1;
            state_next = S_EMIT;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next = S_RXOR;
          end
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.idx_inc = 1'b1;
          if (sts.emit_last) begin
            cmd.crc_init = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/mrtu_datapath.sv
`timescale 1ns / 1ps

module mrtu_datapath
  import mrtu_pkg::*;
#(
  parameter int FRAME_BUFFER_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  rx_word_t   in_word,
  input  logic       out_stall,
  input  mrtu_cmd_t  cmd,
  output mrtu_sts_t  sts,
  output logic       out_valid,
  output tx_word_t   out_word
);

  localparam int CW = $clog2(FRAME_BUFFER_BYTES + 1);

  logic [7:0]    slave_address;
  logic [7:0]    hdr [HDR_BYTES];
  logic [CW-1:0] byte_count;
  logic [15:0]   crc;
  logic [2:0]    bit_cnt;
  logic [2:0]    idx;
  logic          led_level;
  logic          end_held;
  logic          btn_held;
  logic          mode_reply;
  logic [7:0]    reply_byte;
  logic [7:0]    emit_byte;
  logic [15:0]   crc_shifted;
  logic          room;

  assign room = (byte_count < CW'(FRAME_BUFFER_BYTES));

  assign crc_shifted = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);

  always_comb begin
    case (idx)
      POS_ADDR:     reply_byte = slave_address;
      POS_FUNC:     reply_byte = FC_READ_INPUT;
      POS_BYTE_CNT: reply_byte = READ_BYTE_CNT;
      POS_BUTTON:   reply_byte = {7'd0, btn_held};
      POS_CRC_LO:   reply_byte = crc[7:0];
      POS_CRC_HI:   reply_byte = crc[15:8];
      default:      reply_byte = 8'h00;
    endcase
  end

  assign emit_byte = mode_reply ? reply_byte : hdr[idx];

  assign sts.room      = room;
  assign sts.end_held  = end_held;
  assign sts.bit_last  = (bit_cnt == 3'd7);
  assign sts.frame_ok  = (byte_count >= CW'(MIN_FRAME)) && (hdr[POS_ADDR] == slave_address)
                         && (crc == 16'h0000);
  assign sts.is_coil   = (hdr[POS_FUNC] == FC_WRITE_COIL);
  assign sts.is_read   = (hdr[POS_FUNC] == FC_READ_INPUT);
  assign sts.crc_last  = (idx == REPLY_CRC_LAST);
  assign sts.emit_last = mode_reply ? (idx == REPLY_LAST) : (idx == ECHO_LAST);
  assign sts.out_free  = !out_valid || !out_stall;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'h01;
      byte_count    <= '0;
      crc           <= CRC_INIT;
      led_level     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        slave_address <= cfg_wr_data;
      end
      if (cmd.accept && room) begin
        byte_count <= byte_count + CW'(1);
        crc        <= crc ^ {8'h00, in_word.rx_byte};
      end else if (cmd.shift) begin
        crc <= crc_shifted;
      end else if (cmd.rxor) begin
        crc <= crc ^ {8'h00, reply_byte};
      end else if (cmd.check || cmd.crc_init) begin
        crc <= CRC_INIT;
      end
      if (cmd.check) begin
        byte_count <= '0;
        if (sts.frame_ok && sts.is_coil) begin
          if (hdr[POS_COIL] == COIL_ON) begin
            led_level <= 1'b1;
          end else if (hdr[POS_COIL] == COIL_OFF) begin
            led_level <= 1'b0;
          end
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and counters
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      end_held <= in_word.frame_end;
      btn_held <= in_word.button_pressed;
      bit_cnt  <= 3'd0;
      if (byte_count < CW'(HDR_BYTES)) begin
        hdr[byte_count[2:0]] <= in_word.rx_byte;
      end
    end else if (cmd.shift) begin
      bit_cnt <= bit_cnt + 3'd1;
    end else if (cmd.rxor) begin
      bit_cnt <= 3'd0;
    end
    if (cmd.check) begin
      idx        <= 3'd0;
      mode_reply <= !sts.is_coil;
    end else if (cmd.idx_clr) begin
      idx <= 3'd0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 3'd1;
    end
    if (cmd.out_load) begin
      out_word.tx_byte <= emit_byte;
      out_word.tx_last <= sts.emit_last;
      out_word.led_on  <= led_level;
    end
  end

endmodule

FILE: dv/mrtu_reply_checker.sv
`timescale 1ns / 1ps

module mrtu_reply_checker
  import mrtu_pkg::*;
#(
  parameter int FRAME_BUFFER_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  rx_word_t   in_word,
  input  logic       out_valid,
  input  logic       out_stall,
  input  tx_word_t   out_word,
  output int         mismatches = 0,
  output int         replies_owed = 0
);

  logic [7:0]  frame_mem [FRAME_BUFFER_BYTES];
  int          stored;
  logic [15:0] crc_acc;
  logic        led;
  logic [7:0]  my_addr;
  tx_word_t    reply_q [$];
  tx_word_t    want;

  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic queue_reply(logic [7:0] b, logic last);
    tx_word_t w;
    w.tx_byte = b;
    w.tx_last = last;
    w.led_on  = led;
    reply_q.push_back(w);
  endtask

  // one received word: store it, fold it into the crc, answer at frame end
  task automatic take_rx_word(rx_word_t w);
    logic [7:0]  reply [REPLY_LAST + 1];
    logic [15:0] c;
    if (stored < FRAME_BUFFER_BYTES) begin
      frame_mem[stored] = w.rx_byte;
      stored++;
      crc_acc = crc16_step(crc_acc, w.rx_byte);
    end
    if (w.frame_end) begin
      if (stored >= MIN_FRAME && frame_mem[POS_ADDR] == my_addr && crc_acc == 16'h0000) begin
        if (frame_mem[POS_FUNC] == FC_WRITE_COIL) begin
          if (frame_mem[POS_COIL] == COIL_ON) led = 1'b1;
          else if (frame_mem[POS_COIL] == COIL_OFF) led = 1'b0;
          for (int k = 0; k < HDR_BYTES; k++) queue_reply(frame_mem[k], k == ECHO_LAST);
        end else if (frame_mem[POS_FUNC] == FC_READ_INPUT) begin
          reply[POS_ADDR]     = my_addr;
          reply[POS_FUNC]     = FC_READ_INPUT;
          reply[POS_BYTE_CNT] = READ_BYTE_CNT;
          reply[POS_BUTTON]   = {7'd0, w.button_pressed};
          c = CRC_INIT;
          for (int k = 0; k <= REPLY_CRC_LAST; k++) c = crc16_step(c, reply[k]);
          reply[POS_CRC_LO] = c[7:0];
          reply[POS_CRC_HI] = c[15:8];
          for (int k = 0; k <= REPLY_LAST; k++) queue_reply(reply[k], k == REPLY_LAST);
        end
      end
      // receiver rearms after every frame end
      stored  = 0;
      crc_acc = CRC_INIT;
    end
  endtask

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %h, actual %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stored  = 0;
      crc_acc = CRC_INIT;
      led     = 1'b0;
      my_addr = 8'h01;
      reply_q.delete();
    end else begin
      if (cfg_wr_en) my_addr = cfg_wr_data;
      if (in_valid && !in_stall) take_rx_word(in_word);
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          $display("%0t: word expected none, actual %h", $time, out_word);
          mismatches++;
        end else begin
          want = reply_q.pop_front();
          check_field("tx_byte", want.tx_byte, out_word.tx_byte);
          check_field("tx_last", {7'd0, want.tx_last}, {7'd0, out_word.tx_last});
          check_field("led_on", {7'd0, want.led_on}, {7'd0, out_word.led_on});
        end
      end
    end
    replies_owed <= reply_q.size();
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mrtu_pkg::*;

  localparam int BUF_BYTES     = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 60;
  localparam int IDLE_LIMIT    = 3000;
  localparam int PHASE_BYTES   = 18;

  typedef enum logic [1:0] {
    RX_TAKE_ALL,
    RX_STALL_SOME,
    RX_STALL_MOST,
    RX_ALTERNATE
  } stall_mode_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       in_valid = 1'b0;
  rx_word_t   in_word = '0;
  logic       in_stall;
  logic       out_valid;
  logic       out_stall = 1'b0;
  tx_word_t   out_word;
  int         mismatches;
  int         replies_owed;

  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  stall_mode_t stall_mode = RX_TAKE_ALL;
  int          mode_left = 0;
  int          quiet = 0;
  int          burst_left = 0;
  bit          steady = 1'b0;
  int          bytes_sent = 0;
  logic [7:0]  stim_addr = 8'h01;
  logic [7:0]  frame_q [$];

  modbus_rtu_slave_responder #(
    .FRAME_BUFFER_BYTES(BUF_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word)
  );

  mrtu_reply_checker #(
    .FRAME_BUFFER_BYTES(BUF_BYTES)
  ) reply_chk (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word),
    .mismatches(mismatches),
    .replies_owed(replies_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: long hold-off on request, otherwise a changing stall pattern
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(10, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        RX_TAKE_ALL:   out_stall <= 1'b0;
        RX_STALL_SOME: out_stall <= ($urandom_range(0, 3) == 0);
        RX_STALL_MOST: out_stall <= ($urandom_range(0, 3) != 0);
        default:       out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= IDLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic logic [15:0] crc_next(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic put_word(rx_word_t w);
    int gap;
    if (burst_left == 0) begin
      if (steady || $urandom_range(0, 2) == 0) gap = 0;
      else gap = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // body of len-2 bytes, then its crc low and high (one random byte if len < 2), then bytes past the buffer
  task automatic build_frame(int len, logic [7:0] a, logic [7:0] f, logic [7:0] coil,
                             bit good, int tail);
    logic [15:0] c;
    logic [7:0]  b;
    frame_q.delete();
    if (len < 2) begin
      frame_q.push_back(8'($urandom));
    end else begin
      c = CRC_INIT;
      for (int i = 0; i < len - 2; i++) begin
        if (i == POS_ADDR) b = a;
        else if (i == POS_FUNC) b = f;
        else if (i == POS_COIL) b = coil;
        else b = 8'($urandom);
        frame_q.push_back(b);
        c = crc_next(c, b);
      end
      if (!good) c = c ^ (16'h0001 << $urandom_range(0, 15));
      frame_q.push_back(c[7:0]);
      frame_q.push_back(c[15:8]);
    end
    repeat (tail) frame_q.push_back(8'($urandom));
  endtask

  task automatic random_frame();
    int         r;
    int         len;
    int         tail;
    logic [7:0] a;
    logic [7:0] f;
    logic [7:0] coil;
    bit         good;
    a = ($urandom_range(0, 99) < 85) ? stim_addr : 8'($urandom);
    r = $urandom_range(0, 99);
    f = (r < 45) ? FC_WRITE_COIL : (r < 80) ? FC_READ_INPUT : 8'($urandom);
    r = $urandom_range(0, 99);
    coil = (r < 40) ? COIL_ON : (r < 80) ? COIL_OFF : 8'($urandom);
    good = ($urandom_range(0, 99) < 85);
    r = $urandom_range(0, 99);
    tail = 0;
    if (r < 10) len = $urandom_range(1, MIN_FRAME - 1);
    else if (r < 75) len = MIN_FRAME;
    else if (r < 90) len = $urandom_range(MIN_FRAME + 1, BUF_BYTES - 1);
    else begin
      len  = BUF_BYTES;
      tail = $urandom_range(0, 4);
    end
    build_frame(len, a, f, coil, good, tail);
  endtask

  task automatic send_frame(bit end_btn);
    rx_word_t w;
    for (int i = 0; i < frame_q.size(); i++) begin
      w.rx_byte        = frame_q[i];
      w.frame_end      = (i == frame_q.size() - 1);
      w.button_pressed = w.frame_end ? end_btn : 1'($urandom_range(0, 1));
      put_word(w);
      bytes_sent++;
    end
  endtask

  // wait for every reply word, then give a frame that answers nothing time to finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_addr(logic [7:0] a);
    cfg_wr_data <= a;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    stim_addr = a;
  endtask

  initial begin
    int         start;
    logic [7:0] a;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    build_frame(MIN_FRAME, stim_addr, FC_WRITE_COIL, COIL_ON, 1'b1, 0);
    send_frame(1'b0);
    build_frame(MIN_FRAME, stim_addr, FC_READ_INPUT, COIL_OFF, 1'b1, 0);
    send_frame(1'b1);
    // lone byte that ends a frame at once
    frame_q.delete();
    frame_q.push_back(8'hFF);
    send_frame(1'b0);
    build_frame(MIN_FRAME, stim_addr, FC_WRITE_COIL, COIL_OFF, 1'b1, 0);
    send_frame(1'b0);

    for (int p = 0; p < 4; p++) begin
      settle();
      if (p == 0) a = 8'h00;
      else if (p == 1) a = 8'hFF;
      else a = 8'($urandom);
      set_addr(a);
      start = bytes_sent;
      if (p == 1) begin
        // receiver holds off while words keep coming, so the block backs up
        steady = 1'b1;
        hold_req <= hold_req + 1;
        build_frame(MIN_FRAME, stim_addr, FC_WRITE_COIL, 8'($urandom), 1'b1, 0);
        send_frame(1'($urandom_range(0, 1)));
      end
      while (bytes_sent - start < PHASE_BYTES) begin
        random_frame();
        send_frame(1'($urandom_range(0, 1)));
      end
      steady = 1'b0;
    end

    settle();
    if (mismatches == 0 && replies_owed == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
